// ===== rtl/core/sdsc_pkg.sv =====
package sdsc_pkg;

  localparam int unsigned SIZE_BITS = 6;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned ADDR_BITS = 3;

  localparam logic [1:0] STATUS_NEW  = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_LIST = 2'd2;

  localparam logic REG_POPULATION  = 1'b0;
  localparam logic REG_SUBSET_SIZE = 1'b1;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift_out;
  } sdsc_ctrl_t;

endpackage

// ===== rtl/core/sdsc_mod.sv =====
module sdsc_mod #(
  parameter int unsigned VALUE_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] rem_o
);

  localparam int unsigned CNT_BITS = $clog2(VALUE_BITS);

  logic                  busy_q;
  logic                  busy_d;
  logic                  done_q;
  logic                  done_d;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [CNT_BITS-1:0]   cnt_d;
  logic [VALUE_BITS-1:0] dvd_q;
  logic [VALUE_BITS-1:0] dvd_d;
  logic [VALUE_BITS-1:0] div_q;
  logic [VALUE_BITS-1:0] div_d;
  logic [VALUE_BITS-1:0] rem_q;
  logic [VALUE_BITS-1:0] rem_d;
  logic [VALUE_BITS:0]   trial;

  // restoring remainder, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[VALUE_BITS-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(VALUE_BITS - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = VALUE_BITS'(trial - {1'b0, div_q});
      end else begin
        rem_d = VALUE_BITS'(trial);
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/sdsc_cell.sv =====
module sdsc_cell #(
  parameter int unsigned VALUE_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdsc_pkg::sdsc_ctrl_t  ctrl_i,
  input  logic [VALUE_BITS-1:0] cand_i,
  input  logic [VALUE_BITS-1:0] left_val_i,
  input  logic                  left_lt_i,
  input  logic                  left_valid_i,
  input  logic [VALUE_BITS-1:0] right_val_i,
  input  logic                  right_valid_i,
  output logic [VALUE_BITS-1:0] val_o,
  output logic                  valid_o,
  output logic                  lt_o,
  output logic                  eq_o
);

  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] val_d;
  logic                  valid_q;
  logic                  valid_d;
  logic                  lt;

  assign lt   = valid_q && (val_q < cand_i);
  assign eq_o = valid_q && (val_q == cand_i);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      // members below the candidate stay, the rest move one place up
      if (!lt) begin
        val_d = left_lt_i ? cand_i : left_val_i;
      end
      valid_d = valid_q | left_valid_i;
    end else if (ctrl_i.shift_out) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign lt_o    = lt;

endmodule

// ===== rtl/core/sorted_distinct_subset_collector.sv =====
// Collects distinct candidates (random_word mod population, plus one) in a sorted chain of
// cells and lists the subset in ascending order once it holds subset_size members. An item
// is taken when start is high and busy is low; busy then stays high while the bit-serial
// remainder unit, which produces one quotient bit per cycle, works out the candidate and
// while the chain does the sorted insert and duplicate check. Each result appears for
// exactly one cycle with result_valid_o high and cannot be stalled, so the receiver must
// take it on that cycle. An item that completes the subset gives no accept result; instead
// the members follow on consecutive cycles, one per cycle, with last_element_o on the
// final one, and busy stays high until the last member has been listed.
module sorted_distinct_subset_collector #(
  parameter int unsigned MAX_SUBSET = 32,
  parameter int unsigned VALUE_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [VALUE_BITS-1:0]               random_word_i,
  output logic                                result_valid_o,
  output logic [1:0]                          status_o,
  output logic [VALUE_BITS-1:0]               element_o,
  output logic                                last_element_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sdsc_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [sdsc_pkg::DATA_BITS-1:0]      pwdata,
  output logic [sdsc_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  localparam int unsigned CNT_BITS = $clog2(MAX_SUBSET + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;
  localparam logic [1:0] ST_LIST = 2'd3;

  logic [1:0]                     state_q;
  logic [1:0]                     state_d;
  logic [CNT_BITS-1:0]            count_q;
  logic [CNT_BITS-1:0]            count_d;
  logic [VALUE_BITS-1:0]          cand_q;
  logic [VALUE_BITS-1:0]          population_q;
  logic [sdsc_pkg::SIZE_BITS-1:0] subset_size_q;

  logic                  res_valid_q;
  logic                  res_valid_d;
  logic [1:0]            res_status_q;
  logic [1:0]            res_status_d;
  logic [VALUE_BITS-1:0] res_elem_q;
  logic [VALUE_BITS-1:0] res_elem_d;
  logic                  res_last_q;
  logic                  res_last_d;

  logic                  accept;
  logic                  cfg_write;
  logic [VALUE_BITS-1:0] pop_eff;
  logic [7:0]            size_eff;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_rem;
  logic                  dup;
  logic                  full;
  sdsc_pkg::sdsc_ctrl_t  ctrl;

  logic [VALUE_BITS-1:0] cell_val [MAX_SUBSET];
  logic [MAX_SUBSET-1:0] cell_valid;
  logic [MAX_SUBSET-1:0] cell_lt;
  logic [MAX_SUBSET-1:0] cell_eq;

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  assign prdata = (paddr[2] == sdsc_pkg::REG_SUBSET_SIZE) ?
                  sdsc_pkg::DATA_BITS'(subset_size_q) : sdsc_pkg::DATA_BITS'(population_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      population_q  <= VALUE_BITS'(1);
      subset_size_q <= sdsc_pkg::SIZE_BITS'(1);
    end else if (cfg_write) begin
      if (paddr[2] == sdsc_pkg::REG_POPULATION) begin
        population_q <= pwdata[VALUE_BITS-1:0];
      end else begin
        subset_size_q <= pwdata[sdsc_pkg::SIZE_BITS-1:0];
      end
    end
  end

  // zero population counts as one; size is clamped to 1..MAX_SUBSET
  assign pop_eff = (population_q == '0) ? VALUE_BITS'(1) : population_q;

  always_comb begin
    if (subset_size_q == '0) begin
      size_eff = 8'd1;
    end else if (8'(subset_size_q) > 8'(MAX_SUBSET)) begin
      size_eff = 8'(MAX_SUBSET);
    end else begin
      size_eff = 8'(subset_size_q);
    end
  end

  sdsc_mod #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (random_word_i),
    .divisor_i  (pop_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SUBSET; gi++) begin : g_cell
      logic [VALUE_BITS-1:0] left_val;
      logic                  left_lt;
      logic                  left_valid;
      logic [VALUE_BITS-1:0] right_val;
      logic                  right_valid;

      if (gi == 0) begin : g_head
        assign left_val   = '0;
        assign left_lt    = 1'b1;
        assign left_valid = 1'b1;
      end else begin : g_body
        assign left_val   = cell_val[gi-1];
        assign left_lt    = cell_lt[gi-1];
        assign left_valid = cell_valid[gi-1];
      end

      if (gi == MAX_SUBSET - 1) begin : g_tail
        assign right_val   = '0;
        assign right_valid = 1'b0;
      end else begin : g_next
        assign right_val   = cell_val[gi+1];
        assign right_valid = cell_valid[gi+1];
      end

      sdsc_cell #(
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl),
        .cand_i        (cand_q),
        .left_val_i    (left_val),
        .left_lt_i     (left_lt),
        .left_valid_i  (left_valid),
        .right_val_i   (right_val),
        .right_valid_i (right_valid),
        .val_o         (cell_val[gi]),
        .valid_o       (cell_valid[gi]),
        .lt_o          (cell_lt[gi]),
        .eq_o          (cell_eq[gi])
      );
    end
  endgenerate

  assign dup  = |cell_eq;
  assign full = (count_q == CNT_BITS'(MAX_SUBSET));

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    ctrl.insert    = 1'b0;
    ctrl.shift_out = 1'b0;
    res_valid_d    = 1'b0;
    res_status_d   = res_status_q;
    res_elem_d     = res_elem_q;
    res_last_d     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        if (dup || full) begin
          res_valid_d  = 1'b1;
          res_status_d = sdsc_pkg::STATUS_DUP;
          res_elem_d   = cand_q;
          state_d      = ST_IDLE;
        end else begin
          ctrl.insert = 1'b1;
          count_d     = count_q + CNT_BITS'(1);
          if (8'(count_q) + 8'd1 >= size_eff) begin
            state_d = ST_LIST;
          end else begin
            res_valid_d  = 1'b1;
            res_status_d = sdsc_pkg::STATUS_NEW;
            res_elem_d   = cand_q;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_LIST: begin
        // the head cell is listed while the chain moves one place down
        ctrl.shift_out = 1'b1;
        res_valid_d    = 1'b1;
        res_status_d   = sdsc_pkg::STATUS_LIST;
        res_elem_d     = cell_val[0];
        res_last_d     = (count_q == CNT_BITS'(1));
        count_d        = count_q - CNT_BITS'(1);
        if (count_q == CNT_BITS'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      res_last_q  <= res_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_elem_q   <= res_elem_d;
    if (state_q == ST_DIV && div_done) begin
      cand_q <= div_rem + VALUE_BITS'(1);
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign element_o      = res_elem_q;
  assign last_element_o = res_last_q;

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("valid cells do not match the member count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(MAX_SUBSET))
    else $error("member count beyond chain length");

  a_list_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |=> result_valid_o && status_o == sdsc_pkg::STATUS_LIST)
    else $error("listing cycle without a listed member");

  a_last_only_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |-> result_valid_o && status_o == sdsc_pkg::STATUS_LIST && count_q == '0)
    else $error("last marker outside the end of a listing");

  a_accept_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_DIV)
    else $error("accepted transaction did not start the remainder");

endmodule
